@@ hw/rtl/mppd_pkg.sv @@
// mppd_pkg: widths, codes, reset values and the register set type of the press detector
// no dependencies; used by the interfaces, the register block and the top level
package mppd_pkg;

   localparam int NUM_PINS   = 54;   // pins that hold debounce state, 1 to 64
   localparam int PIN_W      = 54;   // width of the level and enable fields
   localparam int IDX_W      = 6;
   localparam int ELAPSED_W  = 10;
   localparam int DEBOUNCE_W = 10;
   localparam int TIMEOUT_W  = 20;
   localparam int PRESS_W    = 11;
   localparam int RUN_W      = 20;
   localparam int EVENT_W    = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [IDX_W-1:0]      BLOCKED_RESET  = 6'd63;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 20'd5000;

   typedef enum logic {
      REQ_CALIBRATE = 1'b0,
      REQ_SAMPLE    = 1'b1
   } req_code_type;

   typedef enum logic [EVENT_W-1:0] {
      EVT_NONE    = 2'd0,
      EVT_DETECT  = 2'd1,
      EVT_TIMEOUT = 2'd2
   } event_code_type;

   typedef enum logic [1:0] {
      REG_ENABLE_MASK = 2'd0,
      REG_BLOCKED_PIN = 2'd1,
      REG_DEBOUNCE_MS = 2'd2,
      REG_TIMEOUT_MS  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [PIN_W-1:0]      enable_mask;
      logic [IDX_W-1:0]      blocked_pin;
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [TIMEOUT_W-1:0]  timeout_ms;
   } cfg_type;

endpackage

@@ hw/rtl/mppd_req_if.sv @@
// mppd_req_if: valid/ready channel that carries one calibrate or sample item
// depends on mppd_pkg for the field widths
interface mppd_req_if
   import mppd_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [PIN_W-1:0]     pin_levels;
   logic [ELAPSED_W-1:0] elapsed_ms;

   modport source (output valid, output req_type, output pin_levels, output elapsed_ms,
                   input ready);
   modport sink   (input valid, input req_type, input pin_levels, input elapsed_ms,
                   output ready);
endinterface

@@ hw/rtl/mppd_rsp_if.sv @@
// mppd_rsp_if: valid/ready channel that carries one result item
// depends on mppd_pkg for the field widths
interface mppd_rsp_if
   import mppd_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_res;
   logic [IDX_W-1:0]   pin_index;

   modport source (output valid, output event_res, output pin_index, input ready);
   modport sink   (input valid, input event_res, input pin_index, output ready);
endinterface

@@ hw/rtl/mppd_csr.sv @@
// mppd_csr: apb-style register block holding enable mask, blocked pin and time limits
// depends on mppd_pkg; registers sit at byte address 8 * index
module mppd_csr
   import mppd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx    = reg_idx_type'(csr_paddr[4:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ENABLE_MASK: cfg_in.enable_mask = csr_pwdata[PIN_W-1:0];
            REG_BLOCKED_PIN: cfg_in.blocked_pin = csr_pwdata[IDX_W-1:0];
            REG_DEBOUNCE_MS: cfg_in.debounce_ms = csr_pwdata[DEBOUNCE_W-1:0];
            REG_TIMEOUT_MS:  cfg_in.timeout_ms  = csr_pwdata[TIMEOUT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ENABLE_MASK: csr_prdata = CSR_DATA_W'(cfg_ff.enable_mask);
         REG_BLOCKED_PIN: csr_prdata = CSR_DATA_W'(cfg_ff.blocked_pin);
         REG_DEBOUNCE_MS: csr_prdata = CSR_DATA_W'(cfg_ff.debounce_ms);
         REG_TIMEOUT_MS:  csr_prdata = CSR_DATA_W'(cfg_ff.timeout_ms);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_mask <= '0;
         cfg_ff.blocked_pin <= BLOCKED_RESET;
         cfg_ff.debounce_ms <= DEBOUNCE_RESET;
         cfg_ff.timeout_ms  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/multi_pin_press_detector.sv @@
// multi_pin_press_detector: an accepted item waits in the input stage, its result
// item in the result stage, held while the result channel stalls; 1 item per cycle
// when results are taken, as the timer update and lowest-index pick are combinational
// reset: detector disarmed, every sample answers "nothing" until a calibrate item;
// registers take their reset values at once, no clearing pass
module multi_pin_press_detector
   import mppd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mppd_req_if.sink              req_chan,
   mppd_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   mppd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   req_code_type         s1_type_ff;
   logic [PIN_W-1:0]     s1_levels_ff;
   logic [ELAPSED_W-1:0] s1_elapsed_ff;
   logic                 advance;
   logic                 req_fire;
   logic                 work;

   // result stage
   logic                 rsp_valid_ff, rsp_valid_in;
   event_code_type       rsp_event_ff;
   logic [IDX_W-1:0]     rsp_index_ff;

   // detector state
   logic [NUM_PINS-1:0]  idle_levels_ff, idle_levels_in;
   logic [NUM_PINS-1:0]  press_seen_ff, press_seen_in;
   logic [NUM_PINS-1:0]  fired_ff, fired_in;
   logic [PRESS_W-1:0]   press_time_ff [NUM_PINS];
   logic [PRESS_W-1:0]   press_time_in [NUM_PINS];
   logic [RUN_W-1:0]     run_time_ff, run_time_in;
   logic                 finished_ff, finished_in;

   // per-item logic
   logic [NUM_PINS-1:0]  levels_ext;
   logic [NUM_PINS-1:0]  mon;
   logic [NUM_PINS-1:0]  pressed;
   logic [NUM_PINS-1:0]  cand;
   logic [NUM_PINS-1:0]  low_bit;
   logic [NUM_PINS-1:0]  above_fire;
   logic [PRESS_W-1:0]   time_sat [NUM_PINS];
   logic [IDX_W-1:0]     fire_idx;
   logic                 fire_any;
   logic                 detect;
   logic [RUN_W:0]       run_sum;
   logic [RUN_W-1:0]     run_sat;
   logic                 sample_live;
   event_code_type       ev;
   logic [IDX_W-1:0]     ev_idx;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign work           = s1_valid_ff && advance;
   assign s1_valid_in    = req_chan.ready ? req_chan.valid : s1_valid_ff;
   assign rsp_valid_in   = advance ? s1_valid_ff : rsp_valid_ff;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.event_res = rsp_event_ff;
   assign rsp_chan.pin_index = rsp_index_ff;

   for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
      logic [PRESS_W:0] time_sum;
      if (p < PIN_W) begin : g_field
         assign levels_ext[p] = s1_levels_ff[p];
         assign mon[p]        = cfg.enable_mask[p];
      end else begin : g_pad
         assign levels_ext[p] = 1'b0;
         assign mon[p]        = 1'b0;
      end
      assign time_sum    = {1'b0, press_time_ff[p]} + (PRESS_W + 1)'(s1_elapsed_ff);
      assign time_sat[p] = time_sum[PRESS_W] ? '1 : time_sum[PRESS_W-1:0];
      assign cand[p]     = mon[p] && pressed[p] && press_seen_ff[p] && !fired_ff[p]
                           && (time_sat[p] > PRESS_W'(cfg.debounce_ms));
   end

   assign pressed = levels_ext ^ idle_levels_ff;

   // lowest firing pin, and the pins above it that keep their state
   assign low_bit    = cand & (~cand + NUM_PINS'(1));
   assign above_fire = ~(low_bit | (low_bit - NUM_PINS'(1)));
   assign fire_any   = |cand;

   always_comb begin
      fire_idx = '0;
      for (int p = 0; p < NUM_PINS; p++) begin
         if (low_bit[p]) fire_idx = fire_idx | IDX_W'(p);
      end
   end

   assign detect      = fire_any && (fire_idx != cfg.blocked_pin);
   assign run_sum     = {1'b0, run_time_ff} + (RUN_W + 1)'(s1_elapsed_ff);
   assign run_sat     = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
   assign sample_live = (s1_type_ff == REQ_SAMPLE) && !finished_ff;

   always_comb begin
      ev     = EVT_NONE;
      ev_idx = '0;
      if (sample_live) begin
         if (detect) begin
            ev     = EVT_DETECT;
            ev_idx = fire_idx;
         end else if ((cfg.timeout_ms != '0) && (run_sat > cfg.timeout_ms)) begin
            ev = EVT_TIMEOUT;
         end
      end
   end

   always_comb begin
      idle_levels_in = idle_levels_ff;
      press_seen_in  = press_seen_ff;
      fired_in       = fired_ff;
      press_time_in  = press_time_ff;
      run_time_in    = run_time_ff;
      finished_in    = finished_ff;
      if (work) begin
         if (s1_type_ff == REQ_CALIBRATE) begin
            idle_levels_in = levels_ext;
            press_seen_in  = '0;
            fired_in       = '0;
            for (int p = 0; p < NUM_PINS; p++) press_time_in[p] = '0;
            run_time_in    = '0;
            finished_in    = 1'b0;
         end else if (sample_live) begin
            for (int p = 0; p < NUM_PINS; p++) begin
               if (mon[p] && !above_fire[p]) begin
                  if (!pressed[p]) begin
                     press_seen_in[p] = 1'b0;
                     press_time_in[p] = '0;
                     fired_in[p]      = 1'b0;
                  end else if (!press_seen_ff[p]) begin
                     press_seen_in[p] = 1'b1;
                  end else begin
                     press_time_in[p] = time_sat[p];
                     fired_in[p]      = fired_ff[p] | low_bit[p];
                  end
               end
            end
            run_time_in = run_sat;
            if (ev != EVT_NONE) finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         idle_levels_ff <= '0;
         press_seen_ff  <= '0;
         fired_ff       <= '0;
         for (int p = 0; p < NUM_PINS; p++) press_time_ff[p] <= '0;
         run_time_ff    <= '0;
         finished_ff    <= 1'b1;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         idle_levels_ff <= idle_levels_in;
         press_seen_ff  <= press_seen_in;
         fired_ff       <= fired_in;
         press_time_ff  <= press_time_in;
         run_time_ff    <= run_time_in;
         finished_ff    <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff    <= req_code_type'(req_chan.req_type);
         s1_levels_ff  <= req_chan.pin_levels;
         s1_elapsed_ff <= req_chan.elapsed_ms;
      end
      if (work) begin
         rsp_event_ff <= ev;
         rsp_index_ff <= ev_idx;
      end
   end

   // a reported detection or timeout disarms the detector
   a_report_disarms: assert property (@(posedge clock) disable iff (reset)
      work && (ev != EVT_NONE) |=> finished_ff)
      else $error("report did not disarm the detector");

   // nothing is reported while disarmed
   a_silent_when_finished: assert property (@(posedge clock) disable iff (reset)
      work && finished_ff |-> ev == EVT_NONE)
      else $error("report while disarmed");

   // the blocked pin is never reported
   a_no_blocked: assert property (@(posedge clock) disable iff (reset)
      work && (ev == EVT_DETECT) |-> fire_any && (ev_idx != cfg.blocked_pin))
      else $error("blocked pin reported");

   // at most one pin fires per item
   a_single_fire: assert property (@(posedge clock) disable iff (reset)
      work |-> $onehot0(low_bit) && ($countones(fired_in & ~fired_ff) <= 1))
      else $error("more than one pin fired");

   // run clock only moves back on calibration
   a_run_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(work && (s1_type_ff == REQ_CALIBRATE)) |=> run_time_ff >= $past(run_time_ff))
      else $error("run clock went backward");

endmodule

@@ tb/tb.sv @@
// tb: self-checking testbench for multi_pin_press_detector, a directed script then random sessions
// depends on mppd_pkg, mppd_req_if and mppd_rsp_if; results checked against an in-bench predictor
module tb;
   import mppd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TARGET_ITEMS   = 1800;
   localparam logic [PIN_W-1:0]   ALL_PINS  = '1;
   localparam logic [PIN_W-1:0]   TOP_PIN   = {1'b1, {(PIN_W-1){1'b0}}};
   localparam logic [PRESS_W-1:0] PRESS_MAX = '1;
   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

   typedef struct packed {
      event_code_type   ev;
      logic [IDX_W-1:0] idx;
   } press_result_type;

   typedef enum logic {
      ROW_ITEM,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type          kind;
      req_code_type          rtype;
      reg_idx_type           reg_id;
      logic [CSR_DATA_W-1:0] data;
      logic [ELAPSED_W-1:0]  ms;
      bit                    typed;
      event_code_type        ev;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mppd_req_if req_if ();
   mppd_rsp_if rsp_if ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   multi_pin_press_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers and the per-pin state
   cfg_type              cfg = '{enable_mask: '0, blocked_pin: BLOCKED_RESET,
                                 debounce_ms: DEBOUNCE_RESET, timeout_ms: TIMEOUT_RESET};
   logic [PIN_W-1:0]     idle_lv = '0;
   bit                   seen_pin [NUM_PINS];
   logic [PRESS_W-1:0]   held_ms [NUM_PINS];
   bit                   fired_pin [NUM_PINS];
   logic [RUN_W-1:0]     run_ms = '0;
   bit                   disarmed = 1'b1;

   press_result_type     expected_events [$];
   press_result_type     oldest;
   int                   n_err = 0;
   int                   n_items = 0;
   int                   n_detect = 0;
   int                   n_timeout = 0;
   int                   n_writes = 0;
   int                   quiet = 0;
   int                   stall_left = 0;
   bit                   no_idle = 1'b0;
   bit                   no_stall = 1'b0;

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      n_err++;
   endtask

   function automatic press_result_type step_detector(req_code_type kind,
                                                      logic [PIN_W-1:0] lv,
                                                      logic [ELAPSED_W-1:0] ms);
      press_result_type res;
      logic [PIN_W-1:0] pressed;
      logic [PRESS_W:0] t;
      logic [RUN_W:0]   r;
      bit               halt_scan;
      int               p;
      res.ev = EVT_NONE;
      res.idx = '0;
      halt_scan = 1'b0;
      if (kind == REQ_CALIBRATE) begin
         idle_lv = lv;
         for (p = 0; p < NUM_PINS; p++) begin
            seen_pin[p] = 1'b0;
            held_ms[p] = '0;
            fired_pin[p] = 1'b0;
         end
         run_ms = '0;
         disarmed = 1'b0;
         return res;
      end
      if (disarmed)
         return res;
      pressed = lv ^ idle_lv;
      for (p = 0; p < NUM_PINS; p++) begin
         if (!halt_scan && cfg.enable_mask[p]) begin
            if (!pressed[p]) begin
               seen_pin[p] = 1'b0;
               held_ms[p] = '0;
               fired_pin[p] = 1'b0;
            end else if (!seen_pin[p]) begin
               seen_pin[p] = 1'b1;
            end else begin
               t = held_ms[p] + ms;
               held_ms[p] = (t > PRESS_MAX) ? PRESS_MAX : t[PRESS_W-1:0];
               // lowest firing pin ends the scan, higher pins keep their state
               if (!fired_pin[p] && held_ms[p] > cfg.debounce_ms) begin
                  fired_pin[p] = 1'b1;
                  if (p != cfg.blocked_pin) begin
                     res.ev = EVT_DETECT;
                     res.idx = p[IDX_W-1:0];
                  end
                  halt_scan = 1'b1;
               end
            end
         end
      end
      r = run_ms + ms;
      run_ms = (r > RUN_MAX) ? RUN_MAX : r[RUN_W-1:0];
      if (res.ev == EVT_DETECT) begin
         disarmed = 1'b1;
         n_detect++;
      end else if (cfg.timeout_ms != 0 && run_ms > cfg.timeout_ms) begin
         res.ev = EVT_TIMEOUT;
         disarmed = 1'b1;
         n_timeout++;
      end
      return res;
   endfunction

   function automatic logic [PIN_W-1:0] rand_pins();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[PIN_W-1:0];
   endfunction

   function automatic script_row_type item_row(req_code_type kind, logic [PIN_W-1:0] lv,
                                               logic [ELAPSED_W-1:0] ms, bit typed,
                                               event_code_type ev);
      item_row = '{ROW_ITEM, kind, REG_ENABLE_MASK, CSR_DATA_W'(lv), ms, typed, ev};
   endfunction

   function automatic script_row_type write_row(reg_idx_type r, logic [CSR_DATA_W-1:0] v);
      write_row = '{ROW_WRITE, REQ_CALIBRATE, r, v, '0, 1'b0, EVT_NONE};
   endfunction

   task automatic send_item(req_code_type kind, logic [PIN_W-1:0] lv, logic [ELAPSED_W-1:0] ms,
                            bit typed, event_code_type ev);
      int               gap;
      press_result_type want;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= kind;
      req_if.pin_levels <= lv;
      req_if.elapsed_ms <= ms;
      do @(posedge clock); while (!req_if.ready);
      if (kind == REQ_CALIBRATE || !disarmed)
         n_items++;
      want = step_detector(kind, lv, ms);
      // hand-written rows state their answer directly
      if (typed) begin
         want.ev = ev;
         want.idx = '0;
      end
      expected_events.push_back(want);
   endtask

   task automatic csr_write(reg_idx_type r, logic [CSR_DATA_W-1:0] v);
      logic [CSR_DATA_W-1:0] rb;
      req_if.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 3'b000};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rb = '0;
      case (r)
         REG_ENABLE_MASK: begin
            cfg.enable_mask = v[PIN_W-1:0];
            rb[PIN_W-1:0] = cfg.enable_mask;
         end
         REG_BLOCKED_PIN: begin
            cfg.blocked_pin = v[IDX_W-1:0];
            rb[IDX_W-1:0] = cfg.blocked_pin;
         end
         REG_DEBOUNCE_MS: begin
            cfg.debounce_ms = v[DEBOUNCE_W-1:0];
            rb[DEBOUNCE_W-1:0] = cfg.debounce_ms;
         end
         REG_TIMEOUT_MS: begin
            cfg.timeout_ms = v[TIMEOUT_W-1:0];
            rb[TIMEOUT_W-1:0] = cfg.timeout_ms;
         end
         default: ;
      endcase
      // read the register straight back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== rb)
         report($sformatf("%s read back %h, expected %h", r.name(), csr_prdata, rb));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      n_writes++;
   endtask

   task automatic run_session();
      logic [PIN_W-1:0]     idle;
      logic [PIN_W-1:0]     held;
      logic [PIN_W-1:0]     lv;
      logic [ELAPSED_W-1:0] ms;
      int                   n_steps;
      int                   k;
      int                   pin;
      idle = rand_pins();
      held = '0;
      no_idle = ($urandom_range(0, 3) == 0);
      no_stall = ($urandom_range(0, 3) == 0);
      send_item(REQ_CALIBRATE, idle, ELAPSED_W'($urandom()), 1'b0, EVT_NONE);
      n_steps = $urandom_range(5, 60);
      for (k = 0; k < n_steps && !disarmed; k++) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               pin = $urandom_range(0, PIN_W - 1);
               held[pin] = ~held[pin];
            end
            3: held = '0;
            4: held = rand_pins() & rand_pins();
            default: ;
         endcase
         lv = idle ^ held;
         if ($urandom_range(0, 19) == 0)
            lv = rand_pins();
         if ($urandom_range(0, 9) == 0)
            ms = ELAPSED_W'($urandom_range(0, 1023));
         else
            ms = ELAPSED_W'($urandom_range(0, cfg.debounce_ms / 4 + 4));
         send_item(REQ_SAMPLE, lv, ms, 1'b0, EVT_NONE);
      end
      // a late sample after the report must stay silent
      if (disarmed && $urandom_range(0, 3) == 0)
         send_item(REQ_SAMPLE, rand_pins(), ELAPSED_W'($urandom()), 1'b0, EVT_NONE);
   endtask

   // result side: random stall after each accepted item
   always @(posedge clock) begin
      if (reset)
         stall_left = 0;
      else if (rsp_if.valid && rsp_if.ready)
         stall_left = no_stall ? 0 : $urandom_range(0, 10);
      else if (stall_left > 0)
         stall_left--;
      rsp_if.ready <= !reset && stall_left == 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_events.size() == 0) begin
               report($sformatf("result event %0d pin %0d with nothing expected",
                                rsp_if.event_res, rsp_if.pin_index));
            end else begin
               oldest = expected_events.pop_front();
               if (rsp_if.event_res !== oldest.ev)
                  report($sformatf("event_res %0d, expected %s",
                                   rsp_if.event_res, oldest.ev.name()));
               if (rsp_if.pin_index !== oldest.idx)
                  report($sformatf("pin_index %0d, expected %0d",
                                   rsp_if.pin_index, oldest.idx));
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_psel)
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", quiet);
            $display("FAIL multi_pin_press_detector");
            $finish;
         end
      end
   end

   initial begin
      script_row_type        script [$];
      logic [CSR_DATA_W-1:0] en;
      logic [CSR_DATA_W-1:0] blk;
      logic [CSR_DATA_W-1:0] deb;
      logic [CSR_DATA_W-1:0] tmo;
      int                    phase;
      int                    i;

      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_CALIBRATE;
      req_if.pin_levels <= '0;
      req_if.elapsed_ms <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;

      // reset settings, nothing monitored: only the run clock can end a run
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS, 10'd1023, 1'b1, EVT_NONE));
      script.push_back(item_row(REQ_CALIBRATE, '0, 10'd1023, 1'b1, EVT_NONE));
      for (i = 0; i < 4; i++)
         script.push_back(item_row(REQ_SAMPLE, ALL_PINS, 10'd1023, 1'b1, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS, 10'd1023, 1'b1, EVT_TIMEOUT));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS, 10'd0, 1'b1, EVT_NONE));
      // all pins, zero debounce, pin 0 blocked, no timeout
      script.push_back(write_row(REG_ENABLE_MASK, CSR_DATA_W'(ALL_PINS)));
      script.push_back(write_row(REG_BLOCKED_PIN, 0));
      script.push_back(write_row(REG_DEBOUNCE_MS, 0));
      script.push_back(write_row(REG_TIMEOUT_MS, 0));
      script.push_back(item_row(REQ_CALIBRATE, ALL_PINS, 10'd0, 1'b1, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS ^ PIN_W'(1), 10'd0, 1'b1, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS ^ PIN_W'(1), 10'd1, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS, 10'd0, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS ^ PIN_W'(1), 10'd0, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS ^ PIN_W'(1), 10'd1023, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS ^ PIN_W'(33), 10'd0, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS ^ PIN_W'(33), 10'd1, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, ALL_PINS, 10'd1023, 1'b1, EVT_NONE));
      // top pin blocked, longest debounce, largest timeout, press time saturates
      script.push_back(write_row(REG_BLOCKED_PIN, CSR_DATA_W'(PIN_W - 1)));
      script.push_back(write_row(REG_DEBOUNCE_MS, 1023));
      script.push_back(write_row(REG_TIMEOUT_MS, CSR_DATA_W'(20'hFFFFF)));
      script.push_back(item_row(REQ_CALIBRATE, '0, 10'd0, 1'b1, EVT_NONE));
      for (i = 0; i < 4; i++)
         script.push_back(item_row(REQ_SAMPLE, TOP_PIN, 10'd1023, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, TOP_PIN | (TOP_PIN >> 1), 10'd1023, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, TOP_PIN | (TOP_PIN >> 1), 10'd1023, 1'b0, EVT_NONE));
      script.push_back(item_row(REQ_SAMPLE, TOP_PIN | (TOP_PIN >> 1), 10'd1, 1'b0, EVT_NONE));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[j]) begin
         if (script[j].kind == ROW_WRITE)
            csr_write(script[j].reg_id, script[j].data);
         else
            send_item(script[j].rtype, script[j].data[PIN_W-1:0], script[j].ms,
                      script[j].typed, script[j].ev);
      end

      phase = 0;
      while (n_items < TARGET_ITEMS) begin
         case (phase)
            0: begin
               en = '0;
               blk = 0;
               deb = 0;
               tmo = 1;
            end
            1: begin
               en = CSR_DATA_W'(ALL_PINS);
               blk = 63;
               deb = 1023;
               tmo = CSR_DATA_W'(20'hFFFFF);
            end
            2: begin
               en = CSR_DATA_W'(ALL_PINS);
               blk = 0;
               deb = 0;
               tmo = 0;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: en = CSR_DATA_W'(ALL_PINS);
                  1: en = CSR_DATA_W'(rand_pins());
                  2: en = CSR_DATA_W'(rand_pins() & rand_pins());
                  default: en = CSR_DATA_W'(rand_pins() | rand_pins());
               endcase
               blk = CSR_DATA_W'($urandom_range(0, 1) ? 63 : $urandom_range(0, 63));
               case ($urandom_range(0, 3))
                  0: deb = CSR_DATA_W'($urandom_range(0, 15));
                  1: deb = CSR_DATA_W'($urandom_range(0, 1023));
                  default: deb = CSR_DATA_W'($urandom_range(10, 120));
               endcase
               case ($urandom_range(0, 3))
                  0: tmo = 0;
                  1: tmo = CSR_DATA_W'($urandom_range(1, 200));
                  2: tmo = CSR_DATA_W'($urandom_range(200, 5000));
                  default: tmo = CSR_DATA_W'($urandom_range(0, 20'hFFFFF));
               endcase
            end
         endcase
         csr_write(REG_ENABLE_MASK, en);
         csr_write(REG_BLOCKED_PIN, blk);
         csr_write(REG_DEBOUNCE_MS, deb);
         csr_write(REG_TIMEOUT_MS, tmo);
         repeat ($urandom_range(3, 8)) run_session();
         phase++;
      end

      req_if.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("covered %0d items over %0d random settings plus the directed script",
               n_items, phase);
      $display("%0d detections, %0d timeouts, %0d register writes, %0d mismatches",
               n_detect, n_timeout, n_writes, n_err);
      if (n_err == 0)
         $display("PASS multi_pin_press_detector");
      else
         $display("FAIL multi_pin_press_detector");
      $finish;
   end

endmodule
